/* rtl/sequenced_slot_ring_queue_core_macros.svh */
// ---------------------------------------------------------------------------
// sequenced slot ring queue core - assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef SEQUENCED_SLOT_RING_QUEUE_CORE_MACROS_SVH
`define SEQUENCED_SLOT_RING_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define SSRQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssrq assertion failed");

// next-cycle implication
`define SSRQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssrq assertion failed");

`endif

/* rtl/ssrq_pkg.sv */
// ---------------------------------------------------------------------------
// ssrq_pkg
// types, constants and codes of the sequenced slot ring queue core
// ---------------------------------------------------------------------------
`default_nettype none

package ssrq_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_BYTES  = 64;
  localparam int TICKET_BITS = 32;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int OFF_W       = 10;

  typedef enum logic [2:0] {
    OP_TAKE_WR  = 3'd0,
    OP_CHECK_WR = 3'd1,
    OP_COMMIT_WR = 3'd2,
    OP_TAKE_RD  = 3'd3,
    OP_CHECK_RD = 3'd4,
    OP_COMMIT_RD = 3'd5,
    OP_POP      = 3'd6,
    OP_STATUS   = 3'd7
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] ticket_in;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [31:0]      ticket_out;
    logic [OFF_W-1:0] slot_offset;
    logic [31:0]      fill_count;
    logic             is_empty;
    logic             is_full;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/ssrq_ctrl.sv */
// ---------------------------------------------------------------------------
// ssrq_ctrl
// request sequencer: accepts a beat and runs one execute cycle
// ---------------------------------------------------------------------------
`default_nettype none

module ssrq_ctrl import ssrq_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  output logic busy,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ssrq_dpath.sv */
// ---------------------------------------------------------------------------
// ssrq_dpath
// ticket counters, slot sequence words and result register
// ---------------------------------------------------------------------------
`default_nettype none

module ssrq_dpath import ssrq_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  cmd_t cmd,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  req_t                   req_q;
  logic [TICKET_BITS-1:0] seq [SLOTS];
  logic [TICKET_BITS-1:0] wc, rc;
  logic [TICKET_BITS-1:0] wc_next, rc_next;
  logic [TICKET_BITS-1:0] tk, seq_rd, tout, wr_data, fill;
  logic [OFF_W-1:0]       off_full;
  logic [SLOT_W-1:0]      slot;
  logic                   hit, granted, wr_en;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  always_comb begin
    tk      = TICKET_BITS'(req_q.ticket_in);
    // slot count is a power of two: modulo is the low bits
    slot    = (req_q.req_type == OP_POP) ? rc[SLOT_W-1:0] : tk[SLOT_W-1:0];
    seq_rd  = seq[slot];
    wc_next = wc;
    rc_next = rc;
    tout    = '0;
    hit     = 1'b0;
    granted = 1'b1;
    wr_en   = 1'b0;
    wr_data = '0;
    case (req_q.req_type)
      OP_TAKE_WR: begin
        tout    = wc;
        wc_next = wc + TICKET_BITS'(1);
      end
      OP_CHECK_WR: begin
        hit     = (seq_rd == tk);
        granted = hit;
      end
      OP_COMMIT_WR: begin
        wr_en   = 1'b1;
        wr_data = ~tk;
      end
      OP_TAKE_RD: begin
        tout    = rc;
        rc_next = rc + TICKET_BITS'(1);
      end
      OP_CHECK_RD: begin
        hit     = (seq_rd == ~tk);
        granted = hit;
      end
      OP_COMMIT_RD: begin
        wr_en   = 1'b1;
        wr_data = tk + TICKET_BITS'(SLOTS);
      end
      OP_POP: begin
        tout    = rc;
        rc_next = rc + TICKET_BITS'(1);
        wr_en   = 1'b1;
        wr_data = rc + TICKET_BITS'(SLOTS);
      end
      default: begin
      end
    endcase
    fill     = (wc_next < rc_next) ? '0 : (wc_next - rc_next);
    off_full = OFF_W'(slot) * OFF_W'(SLOT_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wc   <= '0;
      rc   <= '0;
      done <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        seq[i] <= TICKET_BITS'(i);
      end
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        wc <= wc_next;
        rc <= rc_next;
        if (wr_en) begin
          seq[slot] <= wr_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.granted     <= granted;
      rsp.ticket_out  <= 32'(tout);
      rsp.slot_offset <= hit ? off_full : '0;
      rsp.fill_count  <= 32'(fill);
      rsp.is_empty    <= (fill == '0);
      rsp.is_full     <= (fill >= TICKET_BITS'(SLOTS));
    end
  end

endmodule

`default_nettype wire

/* rtl/sequenced_slot_ring_queue_core.sv */
// ---------------------------------------------------------------------------
// sequenced_slot_ring_queue_core
// ticket and slot-sequence manager of a bounded ring queue
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------
//   request  | start, busy        | req (req_type, ticket_in)
//   result   | done (1-cycle)     | rsp (granted .. is_full)
//
// a request is taken when start is high and busy is low; busy then stays
// high for the single execute cycle
// the result strobe comes in the cycle after execute, while the next
// request may already be taken; one result per request
// rst is synchronous: counters clear and every slot word loads its index
// the receiver cannot stall; nothing holds a result back
// ---------------------------------------------------------------------------
`default_nettype none

module sequenced_slot_ring_queue_core import ssrq_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  cmd_t cmd;

  ssrq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  ssrq_dpath u_dpath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

/* rtl/ssrq_checker.sv */
// ---------------------------------------------------------------------------
// ssrq_checker
// port-level checks of the ring queue core, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "sequenced_slot_ring_queue_core_macros.svh"

module ssrq_checker import ssrq_pkg::*; (
  input wire  clk,
  input wire  rst,
  input wire  start,
  input wire  busy,
  input req_t req,
  input wire  done,
  input rsp_t rsp
);

  `SSRQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SSRQ_ASSERT_NEXT(a_busy_one_cycle, busy, !busy && done)
  `SSRQ_ASSERT_NEXT(a_no_spurious_done, !busy, !done)
  `SSRQ_ASSERT_NOW(a_empty_flag, done, rsp.is_empty == (rsp.fill_count == 32'd0))
  `SSRQ_ASSERT_NOW(a_offset_on_grant, done && !rsp.granted, rsp.slot_offset == '0)

endmodule

bind sequenced_slot_ring_queue_core ssrq_checker u_ssrq_checker (.*);

`default_nettype wire
